/* rtl/core/plc_pkg.sv */
// ----------------------------------------------------------------------------
// plc_pkg
// Map codes, color key tables and helpers for the piecewise linear colormap.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int KEY_W        = 8;
    localparam int NUM_CH       = 4;
    localparam int ALPHA_CH     = 3;
    localparam int HOT_SEG_BITS = 4;
    localparam int HOT_IDX_W    = HOT_SEG_BITS + 1;
    localparam int MAP_W        = 3;

    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [HOT_IDX_W-1:0] hot_idx_t;
    typedef logic [MAP_W-1:0]     map_code_t;

    localparam map_code_t MAP_INTENSITY = 3'd0;
    localparam map_code_t MAP_HOT_ALPHA = 3'd1;
    localparam map_code_t MAP_HOT       = 3'd2;
    localparam map_code_t MAP_RED       = 3'd3;
    localparam map_code_t MAP_GREEN     = 3'd4;
    localparam map_code_t MAP_BLUE      = 3'd5;

    localparam key_t KEY_MAX  = 8'd255;
    localparam key_t KEY_ZERO = 8'd0;

    typedef struct packed {
        key_t r;
        key_t g;
        key_t b;
    } rgb_key_t;

    function automatic rgb_key_t hot_rgb(input hot_idx_t idx);
        rgb_key_t k;
        case (idx)
            5'd0:    k = '{r: 8'd0,   g: 8'd0,   b: 8'd189};
            5'd1:    k = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
            5'd2:    k = '{r: 8'd0,   g: 8'd66,  b: 8'd255};
            5'd3:    k = '{r: 8'd0,   g: 8'd132, b: 8'd255};
            5'd4:    k = '{r: 8'd0,   g: 8'd189, b: 8'd255};
            5'd5:    k = '{r: 8'd0,   g: 8'd255, b: 8'd255};
            5'd6:    k = '{r: 8'd66,  g: 8'd255, b: 8'd189};
            5'd7:    k = '{r: 8'd132, g: 8'd255, b: 8'd132};
            5'd8:    k = '{r: 8'd189, g: 8'd255, b: 8'd66};
            5'd9:    k = '{r: 8'd255, g: 8'd255, b: 8'd0};
            5'd10:   k = '{r: 8'd255, g: 8'd189, b: 8'd0};
            5'd11:   k = '{r: 8'd255, g: 8'd132, b: 8'd0};
            5'd12:   k = '{r: 8'd255, g: 8'd66,  b: 8'd0};
            5'd13:   k = '{r: 8'd255, g: 8'd0,   b: 8'd0};
            5'd14:   k = '{r: 8'd189, g: 8'd0,   b: 8'd0};
            5'd15:   k = '{r: 8'd132, g: 8'd0,   b: 8'd0};
            5'd16:   k = '{r: 8'd128, g: 8'd0,   b: 8'd0};
            default: k = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
        endcase
        return k;
    endfunction

    // alpha ramp key: floor(255 * idx / 16)
    function automatic key_t hot_alpha(input hot_idx_t idx);
        logic [12:0] p;
        p = {idx, 8'b0} - 13'(idx);
        return p[11:4];
    endfunction

endpackage

/* rtl/core/piecewise_linear_colormap.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_colormap
// Maps a signed fixed-point position to red, green, blue and transparency.
// ----------------------------------------------------------------------------
// Takes one position word per clock and returns one color word per clock
// while the output side is ready. A word passes four register stages: key
// lookup, interpolation multiply, reciprocal multiply for the divide by 255,
// and a correction step that feeds the output register. The color word is
// presented from the output register, and it leaves there as soon as the
// output side does not stall. Stages advance independently, so bubbles
// close up and the input keeps accepting while a finished result waits,
// until every stage holds a word. The preset map is chosen through the APB
// register at address 0; change it only while no word is in flight.
// ----------------------------------------------------------------------------
module piecewise_linear_colormap
    import plc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [FRAC_BITS+1:0] position, upper bits zero
    input  logic [((FRAC_BITS+2+7)/8)*8-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // red, green, blue, transparency (FRAC_BITS+1 bits each), upper bits zero
    output logic [((4*(FRAC_BITS+1)+7)/8)*8-1:0] m_axis_tdata,
    // [0] in_range
    output logic [0:0]          m_axis_tuser,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int PW        = FRAC_BITS + 2;
    localparam int OW        = FRAC_BITS + 1;
    localparam int SEG_SHIFT = FRAC_BITS - HOT_SEG_BITS;
    localparam int PRODW     = KEY_W + OW;
    localparam int MW        = FRAC_BITS + KEY_W;
    localparam int RW        = MW - 7;
    localparam int ODW       = ((4*OW+7)/8)*8;
    localparam longint unsigned RECIP_L = (64'd1 << MW) / 255;
    localparam logic [RW-1:0]   RECIP   = RW'(RECIP_L);
    localparam logic [OW-1:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};

    // ---------------- configuration ----------------
    map_code_t map_type_reg;
    logic      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {{(32-MAP_W){1'b0}}, map_type_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_type_reg <= MAP_INTENSITY;
        end
        else if (cfg_write)
        begin
            map_type_reg <= pwdata[MAP_W-1:0];
        end
    end

    // ---------------- stage enables ----------------
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic en0, en1, en2, en3;

    assign en3 = !v3_reg || m_axis_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;
    assign s_axis_tready = en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= s_axis_tvalid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // ---------------- stage 0: key lookup ----------------
    logic [PW-1:0] raw;
    logic [OW-1:0] mag;
    logic          rng_next;
    hot_idx_t      seg_raw;
    hot_idx_t      seg;
    rgb_key_t      hot_a, hot_b;
    key_t          a_next [NUM_CH];
    key_t          b_next [NUM_CH];
    logic [OW-1:0] g_next;

    key_t          a0_reg [NUM_CH];
    key_t          b0_reg [NUM_CH];
    logic [OW-1:0] g0_reg;
    logic          rng0_reg;

    assign raw     = s_axis_tdata[PW-1:0];
    assign mag     = raw[OW-1:0];
    assign seg_raw = mag[FRAC_BITS:SEG_SHIFT];
    assign seg     = seg_raw[HOT_SEG_BITS] ? hot_idx_t'(15) : seg_raw;
    assign hot_a   = hot_rgb(seg);
    assign hot_b   = hot_rgb(seg + hot_idx_t'(1));

    always_comb
    begin
        rng_next = !raw[PW-1] && (mag <= ONE);
        for (int c = 0; c < NUM_CH; c++)
        begin
            a_next[c] = KEY_ZERO;
            b_next[c] = KEY_ZERO;
        end
        a_next[ALPHA_CH] = KEY_MAX;
        b_next[ALPHA_CH] = KEY_MAX;
        g_next = mag;
        case (map_type_reg)
            MAP_HOT_ALPHA, MAP_HOT:
            begin
                a_next[0] = hot_a.r;
                a_next[1] = hot_a.g;
                a_next[2] = hot_a.b;
                b_next[0] = hot_b.r;
                b_next[1] = hot_b.g;
                b_next[2] = hot_b.b;
                if (map_type_reg == MAP_HOT_ALPHA)
                begin
                    a_next[ALPHA_CH] = hot_alpha(seg);
                    b_next[ALPHA_CH] = hot_alpha(seg + hot_idx_t'(1));
                end
                g_next = seg_raw[HOT_SEG_BITS] ? ONE
                                               : {1'b0, mag[SEG_SHIFT-1:0], 4'b0};
            end
            MAP_RED:   b_next[0] = KEY_MAX;
            MAP_GREEN: b_next[1] = KEY_MAX;
            MAP_BLUE:  b_next[2] = KEY_MAX;
            default:
            begin
                b_next[0] = KEY_MAX;
                b_next[1] = KEY_MAX;
                b_next[2] = KEY_MAX;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            a0_reg   <= a_next;
            b0_reg   <= b_next;
            g0_reg   <= g_next;
            rng0_reg <= rng_next;
        end
    end

    // ---------------- stage 1: interpolation ----------------
    logic [OW-1:0] gc;
    logic [MW-1:0] m_next [NUM_CH];
    logic [MW-1:0] m1_reg [NUM_CH];
    logic          rng1_reg;

    assign gc = ONE - g0_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            m_next[c] = MW'(PRODW'(a0_reg[c]) * PRODW'(gc)
                          + PRODW'(b0_reg[c]) * PRODW'(g0_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            m1_reg   <= m_next;
            rng1_reg <= rng0_reg;
        end
    end

    // ---------------- stage 2: reciprocal multiply ----------------
    logic [MW+RW-1:0] p_next [NUM_CH];
    logic [OW-1:0]    q2_reg [NUM_CH];
    logic [MW-1:0]    m2_reg [NUM_CH];
    logic             rng2_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            p_next[c] = (MW+RW)'(m1_reg[c]) * (MW+RW)'(RECIP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                q2_reg[c] <= p_next[c][MW +: OW];
            end
            m2_reg   <= m1_reg;
            rng2_reg <= rng1_reg;
        end
    end

    // ---------------- stage 3: correction and output ----------------
    logic [MW-1:0] rem   [NUM_CH];
    logic [OW-1:0] q_fix [NUM_CH];
    logic [OW-1:0] red_next, green_next, blue_next, transp_next;
    logic [OW-1:0] red_reg, green_reg, blue_reg, transp_reg;
    logic          rng3_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            rem[c]   = m2_reg[c] - ((MW'(q2_reg[c]) << 8) - MW'(q2_reg[c]));
            q_fix[c] = (rem[c] >= MW'(KEY_MAX)) ? q2_reg[c] + OW'(1) : q2_reg[c];
        end
        if (rng2_reg)
        begin
            red_next    = q_fix[0];
            green_next  = q_fix[1];
            blue_next   = q_fix[2];
            transp_next = ONE - q_fix[ALPHA_CH];
        end
        else
        begin
            red_next    = '0;
            green_next  = '0;
            blue_next   = '0;
            transp_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            transp_reg <= transp_next;
            rng3_reg   <= rng2_reg;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = ODW'({transp_reg, blue_reg, green_reg, red_reg});
    assign m_axis_tuser  = rng3_reg;

endmodule

/* rtl/core/plc_checker.sv */
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks for the piecewise linear colormap.
// ----------------------------------------------------------------------------
module plc_checker
#(
    parameter int FRAC_BITS = 16
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [((4*(FRAC_BITS+1)+7)/8)*8-1:0] m_axis_tdata,
    input logic [0:0]          m_axis_tuser,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [2:0]          paddr,
    input logic [31:0]         pwdata,
    input logic [31:0]         prdata
);

    localparam int OW = FRAC_BITS + 1;
    localparam logic [OW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                           && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("out of range word carries nonzero color");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OW-1:0] <= ONE && m_axis_tdata[2*OW-1:OW] <= ONE
                          && m_axis_tdata[3*OW-1:2*OW] <= ONE
                          && m_axis_tdata[4*OW-1:3*OW] <= ONE)
    else $error("channel above full scale");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && !paddr[2])
        && !paddr[2] |-> prdata[2:0] == $past(pwdata[2:0]))
    else $error("map register readback mismatch");

endmodule

bind piecewise_linear_colormap plc_checker #(.FRAC_BITS(FRAC_BITS)) u_plc_checker (.*);

/* sim/piecewise_linear_colormap_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_colormap_checker
// Watches the position and color streams and the map register, predicts
// every color word and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module piecewise_linear_colormap_checker
    import plc_pkg::*;
#(
    parameter int         FRAC_BITS = 16,
    parameter logic [2:0] MAP_ADDR  = 3'd0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [FRAC_BITS+1:0] position
    input  logic [((FRAC_BITS+2+7)/8)*8-1:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red, green, blue, transparency (FRAC_BITS+1 bits each)
    input  logic [((4*(FRAC_BITS+1)+7)/8)*8-1:0] m_axis_tdata,
    // [0] in_range
    input  logic [0:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam int POS_W     = FRAC_BITS + 2;
    localparam int CH_W      = FRAC_BITS + 1;
    localparam int SEG_SHIFT = FRAC_BITS - 4;
    localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;

    // hot key colors, red in the top byte
    localparam logic [23:0] HOT_KEYS [0:16] = '{
        24'h0000BD, 24'h0000FF, 24'h0042FF, 24'h0084FF, 24'h00BDFF, 24'h00FFFF,
        24'h42FFBD, 24'h84FF84, 24'hBDFF42, 24'hFFFF00, 24'hFFBD00, 24'hFF8400,
        24'hFF4200, 24'hFF0000, 24'hBD0000, 24'h840000, 24'h800000
    };

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] transparency;
        logic            in_range;
    } color_word_t;

    map_code_t   map_sel;
    color_word_t color_queue [$];
    color_word_t want;
    color_word_t got;
    int          took_in;
    int          took_out;

    function automatic longint unsigned blend(input longint unsigned a, input longint unsigned b,
                                              input longint unsigned w, input longint unsigned f);
        return ((a * (w - f) + b * f) * UNIT) / (w * 255);
    endfunction

    function automatic color_word_t predict_color(input logic [POS_W-1:0] pos,
                                                  input map_code_t map);
        color_word_t     c;
        longint unsigned ka [4];
        longint unsigned kb [4];
        longint unsigned w;
        longint unsigned f;
        longint unsigned seg;
        longint unsigned raw;
        c   = '0;
        raw = pos;
        if (pos[POS_W-1] || raw > UNIT)
            return c;
        if (map == MAP_HOT_ALPHA || map == MAP_HOT)
        begin
            seg = raw >> SEG_SHIFT;
            if (seg > 15)
                seg = 15;
            w = 64'd1 << SEG_SHIFT;
            f = raw - (seg << SEG_SHIFT);
            for (int i = 0; i < 3; i++)
            begin
                ka[i] = HOT_KEYS[seg][23-8*i -: 8];
                kb[i] = HOT_KEYS[seg+1][23-8*i -: 8];
            end
            if (map == MAP_HOT_ALPHA)
            begin
                ka[3] = (255 * seg) >> 4;
                kb[3] = (255 * (seg + 1)) >> 4;
            end
            else
            begin
                ka[3] = 255;
                kb[3] = 255;
            end
        end
        else
        begin
            w = UNIT;
            f = raw;
            ka = '{0, 0, 0, 255};
            case (map)
                MAP_RED:   kb = '{255, 0, 0, 255};
                MAP_GREEN: kb = '{0, 255, 0, 255};
                MAP_BLUE:  kb = '{0, 0, 255, 255};
                default:   kb = '{255, 255, 255, 255};
            endcase
        end
        c.red          = CH_W'(blend(ka[0], kb[0], w, f));
        c.green        = CH_W'(blend(ka[1], kb[1], w, f));
        c.blue         = CH_W'(blend(ka[2], kb[2], w, f));
        c.transparency = CH_W'(UNIT - blend(ka[3], kb[3], w, f));
        c.in_range     = 1'b1;
        return c;
    endfunction

    task automatic check_field(input string name, input logic [CH_W-1:0] expected,
                               input logic [CH_W-1:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_sel    <= MAP_INTENSITY;
            pending    <= 0;
            fail_count = 0;
            color_queue.delete();
        end
        else
        begin
            took_in  = (s_axis_tvalid && s_axis_tready) ? 1 : 0;
            took_out = (m_axis_tvalid && m_axis_tready) ? 1 : 0;
            if (psel && penable && pwrite && pready && paddr == MAP_ADDR)
                map_sel <= pwdata[MAP_W-1:0];
            if (took_out != 0)
            begin
                got.red          = m_axis_tdata[CH_W-1:0];
                got.green        = m_axis_tdata[2*CH_W-1:CH_W];
                got.blue         = m_axis_tdata[3*CH_W-1:2*CH_W];
                got.transparency = m_axis_tdata[4*CH_W-1:3*CH_W];
                got.in_range     = m_axis_tuser[0];
                if (color_queue.size() == 0)
                begin
                    $error("color word with no position pending");
                    fail_count++;
                end
                else
                begin
                    want = color_queue.pop_front();
                    check_field("red", want.red, got.red);
                    check_field("green", want.green, got.green);
                    check_field("blue", want.blue, got.blue);
                    check_field("transparency", want.transparency, got.transparency);
                    check_field("in_range", CH_W'(want.in_range), CH_W'(got.in_range));
                end
            end
            if (took_in != 0)
                color_queue.insert(color_queue.size(),
                                   predict_color(s_axis_tdata[POS_W-1:0], map_sel));
            pending <= pending + took_in - took_out;
        end
    end

endmodule

/* sim/piecewise_linear_colormap_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_colormap_tb
// Drives positions through every preset map, including the unused codes,
// with bursty input and a stalling output side. A checker beside the block
// predicts each color word; this module makes the stimulus and the verdict.
// ----------------------------------------------------------------------------
module piecewise_linear_colormap_tb
    import plc_pkg::*;
();

    localparam int FRAC_BITS = 16;
    localparam int POS_W     = FRAC_BITS + 2;
    localparam int IN_W      = ((FRAC_BITS + 2 + 7) / 8) * 8;
    localparam int OUT_W     = ((4 * (FRAC_BITS + 1) + 7) / 8) * 8;
    localparam int UNIT      = 1 << FRAC_BITS;
    localparam int KEY_STEP  = 1 << (FRAC_BITS - 4);
    localparam int PHASES    = 10;
    localparam int PER_PHASE = 168;
    localparam int HOLD_LEN  = 300;
    localparam int SETTLE    = 8;
    localparam int LIMIT     = 400000;

    localparam logic [2:0] REG_MAP_TYPE = 3'd0;
    localparam map_code_t  MAP_SPARE6   = 3'd6;
    localparam map_code_t  MAP_SPARE7   = 3'd7;

    logic             clk;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [0:0]       m_axis_tuser;
    logic             psel          = 1'b0;
    logic             penable       = 1'b0;
    logic             pwrite        = 1'b0;
    logic [2:0]       paddr         = '0;
    logic [31:0]      pwdata        = '0;
    logic [31:0]      prdata;
    logic             pready;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int burst_left   = 0;
    int gapless_left = 0;
    int hold_reqs    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int ready_mode   = 0;
    int mode_left    = 0;

    int intensity_points [$] = '{0, 1, 32768, 65535, 65536, 65537, -1, 131071};
    int hot_points [$] = '{0, 1, 2048, 4095, 4096, 4097, 8192, 32768, 36864,
                           61439, 61440, 65535, 65536, 65537, -1, -131072, 131071};
    map_code_t phase_maps [PHASES] = '{MAP_INTENSITY, MAP_HOT_ALPHA, MAP_HOT, MAP_RED,
                                       MAP_GREEN, MAP_BLUE, MAP_SPARE6, MAP_SPARE7,
                                       MAP_HOT, MAP_HOT_ALPHA};

    piecewise_linear_colormap #(.FRAC_BITS(FRAC_BITS)) DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    piecewise_linear_colormap_checker #(.FRAC_BITS(FRAC_BITS), .MAP_ADDR(REG_MAP_TYPE)) scoreboard
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("piecewise_linear_colormap_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_LEN;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (ready_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_colors();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic select_map(input map_code_t map);
        drain_colors();
        repeat (SETTLE) @(posedge clk);
        write_reg(REG_MAP_TYPE, 32'(map));
    endtask

    task automatic send_position(input logic [POS_W-1:0] pos);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(pos);
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic pace_sender();
        int gap;
        if (gapless_left > 0)
        begin
            gapless_left--;
            return;
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    function automatic logic [POS_W-1:0] random_position();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return POS_W'($urandom_range(0, UNIT));
        else if (pick < 70)
            return POS_W'($urandom_range(0, 16) * KEY_STEP + $urandom_range(0, 2) - 1);
        else if (pick < 78)
            return POS_W'($urandom_range(UNIT + 1, (1 << (POS_W - 1)) - 1));
        else if (pick < 86)
            return {1'b1, (POS_W-1)'($urandom)};
        else
            return POS_W'($urandom);
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (intensity_points[i])
            send_position(POS_W'(intensity_points[i]));
        select_map(MAP_HOT_ALPHA);
        foreach (hot_points[i])
            send_position(POS_W'(hot_points[i]));

        for (int p = 0; p < PHASES; p++)
        begin
            select_map(phase_maps[p]);
            for (int n = 0; n < PER_PHASE; n++)
            begin
                if (p == 2 && n == 10)
                begin
                    hold_reqs    <= hold_reqs + 1;
                    gapless_left = 80;
                end
                if (gapless_left == 0 && $urandom_range(0, 79) == 0)
                    drain_colors();
                pace_sender();
                send_position(random_position());
            end
        end

        drain_colors();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("piecewise_linear_colormap_tb passed");
        else
            $display("piecewise_linear_colormap_tb failed");
        $finish;
    end

endmodule
